// File: src/ctcu_pkg.sv
// Package with the types, codes and reset values shared by the thermostat controller files.
`timescale 1ns / 1ps
`default_nettype none

package ctcu_pkg;

    localparam int TEMP_W  = 12;
    localparam int AGE_W   = 12;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 12;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_TOGGLE = 2'd2;

    localparam logic [1:0] RUN_COOLING  = 2'd1;
    localparam logic [1:0] RUN_FAN_ONLY = 2'd2;

    localparam logic [1:0] FAN_OFF  = 2'd0;
    localparam logic [1:0] FAN_HIGH = 2'd3;

    localparam logic [CIDX_W-1:0] REG_SETPOINT       = 3'd0;
    localparam logic [CIDX_W-1:0] REG_FAN_SETTING    = 3'd1;
    localparam logic [CIDX_W-1:0] REG_RUN_MODE       = 3'd2;
    localparam logic [CIDX_W-1:0] REG_HYSTERESIS     = 3'd3;
    localparam logic [CIDX_W-1:0] REG_FREEZE_LIMIT   = 3'd4;
    localparam logic [CIDX_W-1:0] REG_FREEZE_RELEASE = 3'd5;
    localparam logic [CIDX_W-1:0] REG_RESTART_DELAY  = 3'd6;

    localparam logic [8:0]               RST_SETPOINT       = 9'd384;
    localparam logic [1:0]               RST_FAN_SETTING    = 2'd1;
    localparam logic [1:0]               RST_RUN_MODE       = 2'd1;
    localparam logic [7:0]               RST_HYSTERESIS     = 8'd16;
    localparam logic signed [TEMP_W-1:0] RST_FREEZE_LIMIT   = 12'sd0;
    localparam logic signed [TEMP_W-1:0] RST_FREEZE_RELEASE = 12'sd80;
    localparam logic [AGE_W-1:0]         RST_RESTART_DELAY  = 12'd180;
    localparam logic signed [TEMP_W-1:0] RST_AMBIENT        = 12'sd400;
    localparam logic signed [TEMP_W-1:0] RST_COIL           = 12'sd320;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [TEMP_W-1:0] ambient_temp;
        logic                     ambient_valid;
        logic signed [TEMP_W-1:0] coil_temp;
        logic                     coil_valid;
    } t_in;

    typedef struct packed {
        logic             compressor_relay;
        logic [1:0]       fan_level;
        logic             power_on;
        logic             freeze_alarm;
        logic             restart_wait;
        logic [AGE_W-1:0] lockout_seconds;
    } t_out;

    typedef struct packed {
        logic [8:0]               setpoint;
        logic [1:0]               fan_setting;
        logic [1:0]               run_mode;
        logic [7:0]               hysteresis;
        logic signed [TEMP_W-1:0] freeze_limit;
        logic signed [TEMP_W-1:0] freeze_release;
        logic [AGE_W-1:0]         restart_delay;
    } t_cfg;

endpackage

`default_nettype wire

// File: src/cooling_thermostat_controller_unit.sv
// Top level of the cooling thermostat controller: input register, state update and result register.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted transaction (tick, sensor sample or power toggle) is held in an input register,
// applied to the controller state and, on the same clock edge, captured in the result register
// with the state after that item. The block takes one transaction per clock while the output is
// not stalled; a stall on the output holds the item in the input register.
// Configuration writes are always ready and apply to the next sample.
module cooling_thermostat_controller_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output      logic                          o_in_stall,
    input  wire ctcu_pkg::t_in                 i_in_data,
    output      logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    output ctcu_pkg::t_out                     o_out_data,
    input  wire logic                          i_cfg_valid,
    output      logic                          o_cfg_ready,
    input  wire logic [ctcu_pkg::CIDX_W-1:0]   i_cfg_index,
    input  wire logic [ctcu_pkg::CDATA_W-1:0]  i_cfg_data
);

    ctcu_pkg::t_cfg  w_cfg;
    ctcu_pkg::t_out  w_result;
    ctcu_pkg::t_in   r_in;
    ctcu_pkg::t_out  r_out;
    logic            r_in_valid;
    logic            r_out_valid;
    logic            w_out_free;
    logic            w_step;
    logic            w_in_take;

    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_step      = r_in_valid && w_out_free;
    assign o_in_stall  = r_in_valid && !w_out_free;
    assign w_in_take   = i_in_valid && !o_in_stall;

    ctcu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    ctcu_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in_data;
        end
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: src/ctcu_cfg.sv
// Configuration register bank of the thermostat controller.
`timescale 1ns / 1ps
`default_nettype none

module ctcu_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr,
    input  wire logic [ctcu_pkg::CIDX_W-1:0]   i_index,
    input  wire logic [ctcu_pkg::CDATA_W-1:0]  i_data,
    output ctcu_pkg::t_cfg                     o_cfg
);

    ctcu_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint       <= ctcu_pkg::RST_SETPOINT;
            r_cfg.fan_setting    <= ctcu_pkg::RST_FAN_SETTING;
            r_cfg.run_mode       <= ctcu_pkg::RST_RUN_MODE;
            r_cfg.hysteresis     <= ctcu_pkg::RST_HYSTERESIS;
            r_cfg.freeze_limit   <= ctcu_pkg::RST_FREEZE_LIMIT;
            r_cfg.freeze_release <= ctcu_pkg::RST_FREEZE_RELEASE;
            r_cfg.restart_delay  <= ctcu_pkg::RST_RESTART_DELAY;
        end else if (i_wr) begin
            case (i_index)
                ctcu_pkg::REG_SETPOINT:       r_cfg.setpoint       <= i_data[8:0];
                ctcu_pkg::REG_FAN_SETTING:    r_cfg.fan_setting    <= i_data[1:0];
                ctcu_pkg::REG_RUN_MODE:       r_cfg.run_mode       <= i_data[1:0];
                ctcu_pkg::REG_HYSTERESIS:     r_cfg.hysteresis     <= i_data[7:0];
                ctcu_pkg::REG_FREEZE_LIMIT:   r_cfg.freeze_limit   <= $signed(i_data);
                ctcu_pkg::REG_FREEZE_RELEASE: r_cfg.freeze_release <= $signed(i_data);
                ctcu_pkg::REG_RESTART_DELAY:  r_cfg.restart_delay  <= i_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: src/ctcu_core.sv
// Controller state and the per-transaction update of flags, temperatures and lockout age.
`timescale 1ns / 1ps
`default_nettype none

module ctcu_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire ctcu_pkg::t_in   i_item,
    input  wire ctcu_pkg::t_cfg  i_cfg,
    output ctcu_pkg::t_out       o_result
);

    logic                                   r_power, n_power;
    logic                                   r_comp, n_comp;
    logic                                   r_freeze, n_freeze;
    logic                                   r_wait, n_wait;
    logic                                   r_comp_drv, n_comp_drv;
    logic [1:0]                             r_fan_drv, n_fan_drv;
    logic signed [ctcu_pkg::TEMP_W-1:0]     r_amb, n_amb;
    logic signed [ctcu_pkg::TEMP_W-1:0]     r_coil, n_coil;
    logic [ctcu_pkg::AGE_W-1:0]             r_age, n_age;

    logic signed [ctcu_pkg::TEMP_W:0] w_hi;
    logic signed [ctcu_pkg::TEMP_W:0] w_lo;

    assign w_hi  = $signed({4'b0000, i_cfg.setpoint}) + $signed({5'd0, i_cfg.hysteresis});
    assign w_lo  = $signed({4'b0000, i_cfg.setpoint}) - $signed({5'd0, i_cfg.hysteresis});

    always_comb begin
        n_power    = r_power;
        n_comp     = r_comp;
        n_freeze   = r_freeze;
        n_wait     = r_wait;
        n_comp_drv = r_comp_drv;
        n_fan_drv  = r_fan_drv;
        n_amb      = r_amb;
        n_coil     = r_coil;
        n_age      = r_age;
        if (i_step) begin
            case (i_item.kind)
                ctcu_pkg::KIND_TICK: begin
                    if (r_age != ctcu_pkg::AGE_MAX) begin
                        n_age = r_age + {{(ctcu_pkg::AGE_W-1){1'b0}}, 1'b1};
                    end
                end
                ctcu_pkg::KIND_SAMPLE: begin
                    if (i_item.ambient_valid) begin
                        n_amb = i_item.ambient_temp;
                    end
                    if (i_item.coil_valid) begin
                        n_coil = i_item.coil_temp;
                    end
                    if (!r_freeze && (n_coil < i_cfg.freeze_limit)) begin
                        n_freeze = 1'b1;
                        if (r_comp) begin
                            n_age = '0;
                        end
                        n_comp     = 1'b0;
                        n_comp_drv = 1'b0;
                        n_fan_drv  = ctcu_pkg::FAN_HIGH;
                        n_wait     = 1'b0;
                    end else if (r_freeze) begin
                        if (n_coil > i_cfg.freeze_release) begin
                            n_freeze = 1'b0;
                        end
                    end else if (r_power && (i_cfg.run_mode == ctcu_pkg::RUN_COOLING)) begin
                        if (($signed({n_amb[ctcu_pkg::TEMP_W-1], n_amb}) > w_hi) && !r_comp) begin
                            if (r_age >= i_cfg.restart_delay) begin
                                n_comp = 1'b1;
                                n_wait = 1'b0;
                            end else begin
                                n_wait = 1'b1;
                            end
                        end else if (($signed({n_amb[ctcu_pkg::TEMP_W-1], n_amb}) < w_lo)
                                     && r_comp) begin
                            n_comp = 1'b0;
                            n_age  = '0;
                            n_wait = 1'b0;
                        end
                        n_comp_drv = n_comp;
                        n_fan_drv  = i_cfg.fan_setting;
                    end else begin
                        if (r_comp) begin
                            n_age = '0;
                        end
                        n_comp     = 1'b0;
                        n_comp_drv = 1'b0;
                        n_wait     = 1'b0;
                        if (r_power && (i_cfg.run_mode == ctcu_pkg::RUN_FAN_ONLY)) begin
                            n_fan_drv = i_cfg.fan_setting;
                        end else begin
                            n_fan_drv = ctcu_pkg::FAN_OFF;
                        end
                    end
                end
                ctcu_pkg::KIND_TOGGLE: begin
                    n_power = !r_power;
                    if (r_power) begin
                        if (r_comp) begin
                            n_age = '0;
                        end
                        n_comp     = 1'b0;
                        n_wait     = 1'b0;
                        n_comp_drv = 1'b0;
                        n_fan_drv  = ctcu_pkg::FAN_OFF;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power    <= 1'b1;
            r_comp     <= 1'b0;
            r_freeze   <= 1'b0;
            r_wait     <= 1'b0;
            r_comp_drv <= 1'b0;
            r_fan_drv  <= ctcu_pkg::FAN_OFF;
            r_amb      <= ctcu_pkg::RST_AMBIENT;
            r_coil     <= ctcu_pkg::RST_COIL;
            r_age      <= '0;
        end else begin
            r_power    <= n_power;
            r_comp     <= n_comp;
            r_freeze   <= n_freeze;
            r_wait     <= n_wait;
            r_comp_drv <= n_comp_drv;
            r_fan_drv  <= n_fan_drv;
            r_amb      <= n_amb;
            r_coil     <= n_coil;
            r_age      <= n_age;
        end
    end

    always_comb begin
        o_result.compressor_relay = n_comp_drv;
        o_result.fan_level        = n_fan_drv;
        o_result.power_on         = n_power;
        o_result.freeze_alarm     = n_freeze;
        o_result.restart_wait     = n_wait;
        o_result.lockout_seconds  = n_age;
    end

endmodule

`default_nettype wire
